[design/rsnt_pkg.sv]
// shared types, constants and codes of the ring sample store nearest tracker
package rsnt_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int MAX_DIMS    = 4;
  localparam int VALUE_BITS  = 16;

  localparam int ADDR_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int DIMS_W  = $clog2(MAX_DIMS + 1);
  localparam int DELTA_W = VALUE_BITS + 1;
  localparam int SQ_W    = 2 * DELTA_W;
  localparam int DIST_W  = 2 * VALUE_BITS + 3;
  localparam int CFG_W   = 9;
  localparam int CIDX_W  = 2;

  localparam logic [DIST_W-1:0] DIST_NONE = {DIST_W{1'b1}};

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic signed [DELTA_W-1:0]    delta_t;
  typedef logic [SQ_W-1:0]              sq_t;
  typedef logic [DIST_W-1:0]            dist_t;
  typedef logic [ADDR_W-1:0]            addr_t;
  typedef logic [CNT_W-1:0]             count_t;
  typedef logic [DIMS_W-1:0]            dims_t;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_HALVE  = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  localparam logic [1:0] MODE_TRACK      = 2'd0;
  localparam logic [1:0] MODE_HALVE_ONLY = 2'd1;

  localparam logic [CIDX_W-1:0] CFG_DIMS = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_MODE = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_CAP  = 2'd2;

  // write port of one component lane
  typedef struct packed {
    logic   s_we;
    logic   d_we;
    addr_t  addr;
    value_t s_wd;
    delta_t d_wd;
  } lane_wr_t;

  // one entry moving down the walk pipeline
  typedef struct packed {
    logic                       valid;
    addr_t                      addr;
    dist_t                      near_dist;
    delta_t [MAX_DIMS-1:0]      diff;
    value_t [MAX_DIMS-1:0]      halved;
  } stage_t;

  typedef struct packed {
    value_t [MAX_DIMS-1:0] sample;
    delta_t [MAX_DIMS-1:0] delta;
    dist_t                 near_dist;
    logic                  valid;
  } res_t;

endpackage

[design/rsnt_item_if.sv]
// input item channel
interface rsnt_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic signed [15:0] value_0;
  logic signed [15:0] value_1;
  logic signed [15:0] value_2;
  logic signed [15:0] value_3;
  logic [7:0]  entry_index;

  modport source (output valid, kind, value_0, value_1, value_2, value_3, entry_index,
                  input ready);
  modport sink (input valid, kind, value_0, value_1, value_2, value_3, entry_index,
                output ready);
endinterface

[design/rsnt_result_if.sv]
// result item channel
interface rsnt_result_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] sample_0;
  logic signed [15:0] sample_1;
  logic signed [15:0] sample_2;
  logic signed [15:0] sample_3;
  logic signed [16:0] delta_0;
  logic signed [16:0] delta_1;
  logic signed [16:0] delta_2;
  logic signed [16:0] delta_3;
  logic [34:0] nearest_dist;
  logic [8:0]  stored_count;
  logic        entry_valid;

  modport source (output valid, sample_0, sample_1, sample_2, sample_3, delta_0, delta_1,
                  delta_2, delta_3, nearest_dist, stored_count, entry_valid,
                  input ready);
  modport sink (input valid, sample_0, sample_1, sample_2, sample_3, delta_0, delta_1,
                delta_2, delta_3, nearest_dist, stored_count, entry_valid,
                output ready);
endinterface

[design/rsnt_ram.sv]
// generic single write, single read ram with registered read
module rsnt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end
endmodule

[design/rsnt_lane.sv]
// one component lane: sample and delta memories, difference, square and halving
module rsnt_lane import rsnt_pkg::*; (
  input  logic     clk,
  input  addr_t    rd_addr,
  input  value_t   x,
  input  logic     sq_en,
  input  lane_wr_t wr,
  output value_t   rd_sample,
  output delta_t   rd_delta,
  output delta_t   diff,
  output sq_t      sq,
  output value_t   halved
);
  localparam logic signed [VALUE_BITS+1:0] VMAX = (VALUE_BITS+2)'((1 << (VALUE_BITS-1)) - 1);
  localparam logic signed [VALUE_BITS+1:0] VMIN = -(VALUE_BITS+2)'(1 << (VALUE_BITS-1));

  logic [VALUE_BITS-1:0] s_raw;
  logic [DELTA_W-1:0]    d_raw;
  delta_t                diff_c;
  logic signed [SQ_W-1:0] prod;
  logic signed [VALUE_BITS+1:0] hsum;

  rsnt_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ENTRIES)) u_sample_ram (
    .clk(clk), .we(wr.s_we), .wa(wr.addr), .wd(wr.s_wd), .ra(rd_addr), .rd(s_raw)
  );

  rsnt_ram #(.WIDTH(DELTA_W), .DEPTH(MAX_ENTRIES)) u_delta_ram (
    .clk(clk), .we(wr.d_we), .wa(wr.addr), .wd(wr.d_wd), .ra(rd_addr), .rd(d_raw)
  );

  assign rd_sample = value_t'(s_raw);
  assign rd_delta  = delta_t'(d_raw);

  always_comb begin
    diff_c = delta_t'({x[VALUE_BITS-1], x}) - delta_t'({s_raw[VALUE_BITS-1], s_raw});
    prod   = diff_c * diff_c;
    // floor half of the delta added to the stored sample
    hsum   = $signed({{2{s_raw[VALUE_BITS-1]}}, s_raw})
           + $signed({d_raw[DELTA_W-1], d_raw[DELTA_W-1:1]});
  end

  always_ff @(posedge clk) begin
    diff <= diff_c;
    sq   <= sq_en ? sq_t'(prod) : '0;
    if (hsum > VMAX) begin
      halved <= value_t'(VMAX);
    end else if (hsum < VMIN) begin
      halved <= value_t'(VMIN);
    end else begin
      halved <= value_t'(hsum);
    end
  end
endmodule

[design/rsnt_merge.sv]
// merge stage: sums lane squares, flags closer entries, keeps the running nearest
module rsnt_merge import rsnt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  stage_t                s1,
  input  sq_t [MAX_DIMS-1:0]    sq,
  output stage_t                s2,
  output dist_t                 sum,
  output logic                  closer,
  output dist_t                 best_dist,
  output delta_t [MAX_DIMS-1:0] best_delta
);
  dist_t sum_c;

  always_comb begin
    sum_c = '0;
    for (int j = 0; j < MAX_DIMS; j++) begin
      sum_c = sum_c + DIST_W'(sq[j]);
    end
  end

  assign closer = s2.valid && (sum < s2.near_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2 <= s1;
    end
    sum <= sum_c;
    if (start) begin
      best_dist  <= DIST_NONE;
      best_delta <= '0;
    end else if (s2.valid && (sum < best_dist)) begin
      best_dist <= sum;
      for (int j = 0; j < MAX_DIMS; j++) begin
        best_delta[j] <= -s2.diff[j];
      end
    end
  end
endmodule

[design/ring_sample_store_nearest_tracker_top.sv]
// ring sample store with per-component lanes and a nearest-neighbor merge stage
// a tracking insert into a non-empty store and a halve in mode 0 or 1 walk the store first;
// other inserts write at once, a read fetches one entry, a blocked halve or unknown kind only
// reports; the walk reads one entry a cycle; one item in work at a time, taken only in idle
// reset: rst (synchronous) clears count, pointer and handshakes, restores config defaults;
// store contents stay undefined until written, no clearing pass
module ring_sample_store_nearest_tracker_top import rsnt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  rsnt_item_if.sink          item,
  rsnt_result_if.source      result
);
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_WALK   = 6'b000010,
    ST_WRITE  = 6'b000100,
    ST_RDADDR = 6'b001000,
    ST_RDDATA = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  state_t state;
  logic [2:0] dims_reg;
  logic [1:0] mode_reg;
  logic [CFG_W-1:0] cap_reg;
  count_t entry_count;
  addr_t  write_pointer;

  kind_t  op;
  value_t x [MAX_DIMS];
  addr_t  e_reg;
  count_t idx;
  res_t   res;

  logic   va, s1_v;
  addr_t  aa, s1_a;
  dist_t  s1_dist;
  stage_t s1, s2;
  dist_t  sum, best_dist, dist_rd, dist_wd;
  logic   closer, dist_we, accept, walk_done, load_out;
  addr_t  rd_addr, dist_wa, w;
  delta_t [MAX_DIMS-1:0] best_delta;
  sq_t    [MAX_DIMS-1:0] sq;
  delta_t [MAX_DIMS-1:0] diff;
  value_t [MAX_DIMS-1:0] halved;
  value_t [MAX_DIMS-1:0] rd_sample;
  delta_t [MAX_DIMS-1:0] rd_delta;
  lane_wr_t [MAX_DIMS-1:0] lw;
  dims_t  dims_eff, k;
  count_t cap_eff;
  value_t out_s [MAX_DIMS];
  delta_t out_d [MAX_DIMS];
  dist_t  out_dist;
  count_t out_count;
  logic   out_evalid, out_valid;

  always_comb begin
    if (dims_reg == '0) begin
      dims_eff = dims_t'(1);
    end else if (dims_reg > 3'(MAX_DIMS)) begin
      dims_eff = dims_t'(MAX_DIMS);
    end else begin
      dims_eff = dims_t'(dims_reg);
    end
    if (cap_reg < CFG_W'(2)) begin
      cap_eff = count_t'(2);
    end else if (cap_reg > CFG_W'(MAX_ENTRIES)) begin
      cap_eff = count_t'(MAX_ENTRIES);
    end else begin
      cap_eff = count_t'(cap_reg);
    end
    k = dims_eff - dims_t'(1);
    w = (count_t'(write_pointer) < cap_eff) ? write_pointer : '0;
  end

  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;
  assign walk_done  = (idx >= entry_count) && !va && !s1_v && !s2.valid;
  assign load_out   = (state == ST_RESULT) && (!out_valid || result.ready);

  always_comb begin
    unique case (state)
      ST_WALK:   rd_addr = idx[ADDR_W-1:0];
      ST_RDADDR: rd_addr = e_reg;
      default:   rd_addr = '0;
    endcase
  end

  // lanes, one per component
  for (genvar j = 0; j < MAX_DIMS; j++) begin : g_lane
    rsnt_lane u_lane (
      .clk(clk), .rd_addr(rd_addr), .x(x[j]),
      .sq_en(dims_t'(j + 1) < dims_eff), .wr(lw[j]),
      .rd_sample(rd_sample[j]), .rd_delta(rd_delta[j]),
      .diff(diff[j]), .sq(sq[j]), .halved(halved[j])
    );
  end

  rsnt_ram #(.WIDTH(DIST_W), .DEPTH(MAX_ENTRIES)) u_dist_ram (
    .clk(clk), .we(dist_we), .wa(dist_wa), .wd(dist_wd), .ra(rd_addr), .rd(dist_rd)
  );

  always_comb begin
    s1.valid     = s1_v;
    s1.addr      = s1_a;
    s1.near_dist = s1_dist;
    s1.diff      = diff;
    s1.halved    = halved;
  end

  rsnt_merge u_merge (
    .clk(clk), .rst(rst), .start(accept), .s1(s1), .sq(sq), .s2(s2), .sum(sum),
    .closer(closer), .best_dist(best_dist), .best_delta(best_delta)
  );

  // write ports: final insert write, halve write-back or closer-neighbor update
  always_comb begin
    for (int j = 0; j < MAX_DIMS; j++) begin
      lw[j]      = '0;
      lw[j].addr = s2.addr;
      if (state == ST_WRITE) begin
        lw[j].addr = w;
        lw[j].s_we = 1'b1;
        lw[j].d_we = 1'b1;
        lw[j].s_wd = (dims_t'(j) < dims_eff) ? x[j] : '0;
        lw[j].d_wd = (dims_t'(j) < dims_eff) ? best_delta[j] : '0;
      end else if (op == KIND_HALVE) begin
        lw[j].s_we = s2.valid && (dims_t'(j) == k);
        lw[j].s_wd = s2.halved[j];
      end else begin
        lw[j].d_we = closer && (dims_t'(j) < dims_eff);
        lw[j].d_wd = s2.diff[j];
      end
    end
    if (state == ST_WRITE) begin
      dist_we = 1'b1;
      dist_wa = w;
      if (entry_count == '0) begin
        dist_wd = DIST_NONE;
      end else begin
        dist_wd = (mode_reg == MODE_TRACK) ? best_dist : '0;
      end
    end else begin
      dist_we = closer && (op == KIND_INSERT);
      dist_wa = s2.addr;
      dist_wd = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      dims_reg      <= 3'(MAX_DIMS);
      mode_reg      <= MODE_TRACK;
      cap_reg       <= CFG_W'(MAX_ENTRIES);
      entry_count   <= '0;
      write_pointer <= '0;
      va            <= 1'b0;
      s1_v          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DIMS: dims_reg <= cfg_data[2:0];
          CFG_MODE: mode_reg <= cfg_data[1:0];
          CFG_CAP:  cap_reg  <= cfg_data;
          default: ;
        endcase
      end

      va   <= (state == ST_WALK) && (idx < entry_count);
      s1_v <= va;

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (kind_t'(item.kind))
              KIND_INSERT: begin
                if ((entry_count != '0) && (mode_reg == MODE_TRACK)) begin
                  state <= ST_WALK;
                end else begin
                  state <= ST_WRITE;
                end
              end
              KIND_HALVE: begin
                if (mode_reg <= MODE_HALVE_ONLY) begin
                  state <= ST_WALK;
                end else begin
                  state <= ST_RESULT;
                end
              end
              KIND_READ: state <= ST_RDADDR;
              default:   state <= ST_RESULT;
            endcase
          end
        end
        ST_WALK: begin
          if (walk_done) begin
            state <= (op == KIND_INSERT) ? ST_WRITE : ST_RESULT;
          end
        end
        ST_WRITE: begin
          state <= ST_RESULT;
          if (entry_count == '0) begin
            entry_count   <= count_t'(1);
            write_pointer <= addr_t'(1);
          end else begin
            if (entry_count < cap_eff) begin
              entry_count <= entry_count + count_t'(1);
            end
            if ((count_t'(w) + count_t'(1)) >= cap_eff) begin
              write_pointer <= '0;
            end else begin
              write_pointer <= w + addr_t'(1);
            end
          end
        end
        ST_RDADDR: state <= ST_RDDATA;
        ST_RDDATA: state <= ST_RESULT;
        ST_RESULT: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item latch, walk index, result build, output payload
  always_ff @(posedge clk) begin
    aa      <= idx[ADDR_W-1:0];
    s1_a    <= aa;
    s1_dist <= dist_rd;
    if (accept) begin
      op    <= kind_t'(item.kind);
      x[0]  <= item.value_0;
      x[1]  <= item.value_1;
      x[2]  <= item.value_2;
      x[3]  <= item.value_3;
      e_reg <= item.entry_index;
      idx   <= '0;
      res   <= '0;
    end else if ((state == ST_WALK) && (idx < entry_count)) begin
      idx <= idx + count_t'(1);
    end
    if (state == ST_WRITE) begin
      for (int j = 0; j < MAX_DIMS; j++) begin
        res.sample[j] <= lw[j].s_wd;
        res.delta[j]  <= lw[j].d_wd;
      end
      res.near_dist <= dist_wd;
      res.valid     <= 1'b1;
    end
    if ((state == ST_RDDATA) && (count_t'(e_reg) < entry_count)) begin
      for (int j = 0; j < MAX_DIMS; j++) begin
        res.sample[j] <= (dims_t'(j) < dims_eff) ? rd_sample[j] : '0;
        res.delta[j]  <= (dims_t'(j) < dims_eff) ? rd_delta[j] : '0;
      end
      res.near_dist <= dist_rd;
      res.valid     <= 1'b1;
    end
    if (load_out) begin
      for (int j = 0; j < MAX_DIMS; j++) begin
        out_s[j] <= res.sample[j];
        out_d[j] <= res.delta[j];
      end
      out_dist   <= res.near_dist;
      out_count  <= entry_count;
      out_evalid <= res.valid;
    end
  end

  assign result.valid        = out_valid;
  assign result.sample_0     = out_s[0];
  assign result.sample_1     = out_s[1];
  assign result.sample_2     = out_s[2];
  assign result.sample_3     = out_s[3];
  assign result.delta_0      = out_d[0];
  assign result.delta_1      = out_d[1];
  assign result.delta_2      = out_d[2];
  assign result.delta_3      = out_d[3];
  assign result.nearest_dist = out_dist;
  assign result.stored_count = out_count;
  assign result.entry_valid  = out_evalid;
endmodule
